// File: rtl/sdio_fifo_credit_transfer_planner_core_macros.svh
// Assertion macros for the SDIO FIFO credit and transfer planner.
// Included by the top level; relies on no other file.
`ifndef SDIO_FIFO_CREDIT_TRANSFER_PLANNER_CORE_MACROS_SVH
`define SDIO_FIFO_CREDIT_TRANSFER_PLANNER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SFCTP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SFCTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sfctp_pkg.sv
// Shared constants, codes and control structs of the SDIO FIFO transfer planner.
// Used by the divider, datapath, controller and top level; depends on nothing.
package sfctp_pkg;

    localparam int unsigned BLOCK_BYTES_DEF    = 512;
    localparam int unsigned RX_FRAME_LIMIT_DEF = 2048;

    // Divider and transfer length width; a length may reach 65536.
    localparam int unsigned DIV_W   = 17;
    localparam int unsigned CNT_W   = $clog2(DIV_W + 1);
    localparam int unsigned SENT_W  = 12;
    localparam int unsigned RECV_W  = 20;
    localparam int unsigned FLEN_W  = 16;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [DIV_W-1:0]      FIFO_END_ADDR    = 17'h1F800;
    localparam logic [RECV_W-1:0]     RECV_FLOAT       = 20'hFFFFF;
    localparam logic [CFG_DATA_W-1:0] CREDIT_BUF_RESET = 16'd1536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CREDIT_BUF = 1'b0,
        CFG_LINK_READY = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_NO_CREDIT = 2'd2,
        ST_NOTHING   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        EM_STAT  = 2'd0,
        EM_BLOCK = 2'd1,
        EM_TAIL  = 2'd2
    } t_emit;

    typedef struct packed {
        logic  capture;
        logic  div_start;
        logic  mod_quo;
        logic  mod_rem;
        logic  upd_sent;
        logic  upd_recv;
        logic  emit;
        t_emit kind;
    } t_dp_cmd;

    typedef struct packed {
        logic link_ready;
        logic is_recv;
        logic flen_zero;
        logic pending_zero;
        logic div_busy;
        logic no_credit;
        logic total_ge_block;
        logic rem_zero;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        t_status            status;
        logic [DIV_W-1:0]   command_address;
        logic [DIV_W-1:0]   chunk_bytes;
        logic               block_mode;
        logic               is_write;
        logic [DIV_W-1:0]   payload_bytes;
        logic [SENT_W-1:0]  free_credits;
        logic [RECV_W-1:0]  queued_bytes;
        logic [DIV_W-1:0]   transfer_bytes;
        logic               last;
    } t_res;

endpackage

// File: rtl/sfctp_ifs.sv
// Request and result channel interfaces of the SDIO FIFO transfer planner.
// Valid/ready handshake with the item payload; no package dependency.
interface sfctp_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] frame_length;
    logic [31:0] token_word;
    logic [31:0] length_word;

    modport source(output valid, action, frame_length, token_word, length_word, input ready);
    modport sink(input valid, action, frame_length, token_word, length_word, output ready);
endinterface

interface sfctp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [16:0] command_address;
    logic [16:0] chunk_bytes;
    logic        block_mode;
    logic        is_write;
    logic [16:0] payload_bytes;
    logic [11:0] free_credits;
    logic [19:0] queued_bytes;
    logic [16:0] transfer_bytes;
    logic        last;

    modport source(output valid, status, command_address, chunk_bytes, block_mode, is_write,
                   payload_bytes, free_credits, queued_bytes, transfer_bytes, last,
                   input ready);
    modport sink(input valid, status, command_address, chunk_bytes, block_mode, is_write,
                 payload_bytes, free_credits, queued_bytes, transfer_bytes, last,
                 output ready);
endinterface

// File: rtl/sfctp_div.sv
// Restoring divider, one quotient bit per cycle, for the transfer planner datapath.
// Depends on sfctp_pkg for its widths.
module sfctp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sfctp_pkg::DIV_W-1:0]   i_dividend,
    input  logic [sfctp_pkg::DIV_W-2:0]   i_divisor,
    output logic                          o_busy,
    output logic [sfctp_pkg::DIV_W-1:0]   o_quotient
);
    import sfctp_pkg::*;

    logic [DIV_W-1:0] r_acc, n_acc;
    logic [DIV_W-1:0] r_q, n_q;
    logic [DIV_W-2:0] r_dvs, n_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic [DIV_W-1:0] w_shift;
    logic [DIV_W-1:0] w_diff;
    logic             w_ge;

    // The partial remainder stays below the divisor, so the shift fits.
    assign w_shift = {r_acc[DIV_W-2:0], r_q[DIV_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_comb begin
        n_acc  = r_acc;
        n_q    = r_q;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_acc  = '0;
            n_q    = i_dividend;
            n_dvs  = i_divisor;
            n_cnt  = CNT_W'(DIV_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = w_ge ? w_diff : w_shift;
            n_q   = {r_q[DIV_W-2:0], w_ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_q   <= n_q;
        r_dvs <= n_dvs;
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_q;

endmodule

// File: rtl/sfctp_dp.sv
// Datapath of the transfer planner: configuration, counters, request registers,
// credit divider, block split and the result register. Depends on sfctp_pkg,
// sfctp_ifs, sfctp_div.
module sfctp_dp #(
    parameter int unsigned BLOCK_BYTES    = sfctp_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned RX_FRAME_LIMIT = sfctp_pkg::RX_FRAME_LIMIT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sfctp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sfctp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                               i_action,
    input  logic [sfctp_pkg::FLEN_W-1:0]       i_frame_length,
    input  logic [sfctp_pkg::WORD_W-1:0]       i_token_word,
    input  logic [sfctp_pkg::WORD_W-1:0]       i_length_word,
    input  sfctp_pkg::t_dp_cmd                 i_cmd,
    output sfctp_pkg::t_dp_stat                o_stat,
    sfctp_res_if.source                        o_res
);
    import sfctp_pkg::*;

    localparam logic [DIV_W-1:0]  BlkLen   = DIV_W'(BLOCK_BYTES);
    localparam logic [RECV_W-1:0] RxLimit  = RECV_W'(RX_FRAME_LIMIT);
    // Block size reciprocal, rounded up; it gives the exact quotient for every
    // 17-bit length.
    localparam int unsigned       RecipSh  = DIV_W + $clog2(BLOCK_BYTES);
    localparam int unsigned       RecipW   = DIV_W + 1;
    localparam int unsigned       ProdW    = DIV_W + RecipW;
    localparam logic [RecipW-1:0] RecipM   =
        RecipW'(((64'd1 << RecipSh) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));

    logic [CFG_DATA_W-1:0] r_buf_bytes;
    logic                  r_link;
    logic [SENT_W-1:0]     r_sent;
    logic [RECV_W-1:0]     r_recv;
    logic                  r_act;
    logic [FLEN_W-1:0]     r_flen;
    logic [SENT_W-1:0]     r_freec;
    logic [RECV_W-1:0]     r_pending;
    logic [DIV_W-1:0]      r_total;
    logic [DIV_W-1:0]      r_bq;
    logic [DIV_W-1:0]      r_rem;
    logic                  r_ov;
    t_res                  r_res;
    t_res                  w_res;

    logic [SENT_W-1:0]     w_freec;
    logic [RECV_W-1:0]     w_lw;
    logic [RECV_W-1:0]     w_pend;
    logic [RECV_W-1:0]     w_take;
    logic [DIV_W-1:0]      w_padded;
    logic [DIV_W-2:0]      w_bsz;
    logic [DIV_W-1:0]      w_dividend;
    logic                  w_busy;
    logic [DIV_W-1:0]      w_quo;
    logic [ProdW-1:0]      w_prod;
    logic [DIV_W-1:0]      w_bq;
    logic [DIV_W-1:0]      w_blk_part;
    logic                  w_out_free;

    // Request decode, done against the counters as they stand at accept time.
    assign w_freec  = i_token_word[27:16] - r_sent;
    assign w_lw     = i_length_word[RECV_W-1:0];
    assign w_pend   = (w_lw == RECV_FLOAT) ? '0 : (w_lw - r_recv);
    assign w_take   = (w_pend > RxLimit) ? RxLimit : w_pend;
    assign w_padded = ({1'b0, i_frame_length} + 17'd3) & ~17'd3;

    // A zero buffer size counts as one byte per credit.
    assign w_bsz      = (r_buf_bytes == '0) ? (DIV_W-1)'(1) : r_buf_bytes;
    assign w_dividend = {1'b0, r_flen} + {1'b0, w_bsz} - 17'd1;

    sfctp_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_bsz),
        .o_busy      (w_busy),
        .o_quotient  (w_quo)
    );

    // Whole blocks in the transfer, then the bytes left over for the tail.
    assign w_prod     = r_total * RecipM;
    assign w_bq       = DIV_W'(w_prod >> RecipSh);
    assign w_blk_part = r_bq * BlkLen;

    assign w_out_free = !r_ov || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_bytes <= CREDIT_BUF_RESET;
            r_link      <= 1'b0;
            r_sent      <= '0;
            r_recv      <= '0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_CREDIT_BUF: r_buf_bytes <= i_cfg_data;
                    CFG_LINK_READY: r_link      <= i_cfg_data[0];
                endcase
            end
            if (i_cmd.upd_sent) begin
                r_sent <= r_sent + w_quo[SENT_W-1:0];
            end
            if (i_cmd.upd_recv) begin
                r_recv <= r_recv + RECV_W'(r_total);
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act     <= i_action;
            r_flen    <= i_frame_length;
            r_freec   <= w_freec;
            r_pending <= w_pend;
            r_total   <= i_action ? w_take[DIV_W-1:0] : w_padded;
        end
        if (i_cmd.mod_quo) begin
            r_bq <= w_bq;
        end
        if (i_cmd.mod_rem) begin
            r_rem <= r_total - w_blk_part;
        end
        if (i_cmd.emit) begin
            r_res <= w_res;
        end
    end

    // Result fields for the item the controller asks for.
    always_comb begin
        w_res                 = '0;
        w_res.status          = ST_OK;
        w_res.last            = 1'b1;
        w_res.is_write        = !r_act;
        w_res.free_credits    = r_act ? '0 : r_freec;
        w_res.queued_bytes    = r_act ? r_pending : '0;
        w_res.transfer_bytes  = r_total;
        case (i_cmd.kind)
            EM_BLOCK: begin
                w_res.command_address = FIFO_END_ADDR - r_total;
                w_res.chunk_bytes     = r_total - r_rem;
                w_res.payload_bytes   = r_total - r_rem;
                w_res.block_mode      = 1'b1;
                w_res.last            = (r_rem == '0);
            end
            EM_TAIL: begin
                w_res.command_address = FIFO_END_ADDR - r_rem;
                w_res.chunk_bytes     = (r_rem + 17'd3) & ~17'd3;
                w_res.payload_bytes   = r_rem;
            end
            default: begin
                // Single status item: the command fields stay zero.
                w_res.is_write       = 1'b0;
                w_res.free_credits   = '0;
                w_res.queued_bytes   = '0;
                w_res.transfer_bytes = '0;
                if (!r_link) begin
                    w_res.status = ST_NOT_READY;
                end else if (r_act) begin
                    w_res.status = ST_NOTHING;
                end else if (r_flen != '0) begin
                    w_res.status         = ST_NO_CREDIT;
                    w_res.free_credits   = r_freec;
                    w_res.transfer_bytes = r_total;
                end
            end
        endcase
    end

    always_comb begin
        o_stat.link_ready     = r_link;
        o_stat.is_recv        = r_act;
        o_stat.flen_zero      = (r_flen == '0);
        o_stat.pending_zero   = (r_pending == '0);
        o_stat.div_busy       = w_busy;
        o_stat.no_credit      = {{(DIV_W-SENT_W){1'b0}}, r_freec} < w_quo;
        o_stat.total_ge_block = r_total >= BlkLen;
        o_stat.rem_zero       = (r_rem == '0);
        o_stat.out_free       = w_out_free;
    end

    assign o_res.valid           = r_ov;
    assign o_res.status          = r_res.status;
    assign o_res.command_address = r_res.command_address;
    assign o_res.chunk_bytes     = r_res.chunk_bytes;
    assign o_res.block_mode      = r_res.block_mode;
    assign o_res.is_write        = r_res.is_write;
    assign o_res.payload_bytes   = r_res.payload_bytes;
    assign o_res.free_credits    = r_res.free_credits;
    assign o_res.queued_bytes    = r_res.queued_bytes;
    assign o_res.transfer_bytes  = r_res.transfer_bytes;
    assign o_res.last            = r_res.last;

endmodule

// File: rtl/sfctp_ctrl.sv
// Controller state machine of the transfer planner; sequences the datapath.
// Depends on sfctp_pkg for the command and status structs.
module sfctp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sfctp_pkg::t_dp_stat   i_stat,
    output sfctp_pkg::t_dp_cmd    o_cmd
);
    import sfctp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_CRED   = 7'b0000100,
        S_MOD    = 7'b0001000,
        S_BLK    = 7'b0010000,
        S_TAIL   = 7'b0100000,
        S_STAT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.kind = EM_STAT;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // The whole-block count only needs the captured total.
                o_cmd.mod_quo = 1'b1;
                if (!i_stat.link_ready ||
                    (i_stat.is_recv ? i_stat.pending_zero : i_stat.flen_zero)) begin
                    n_state = S_STAT;
                end else if (!i_stat.is_recv) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_CRED;
                end else begin
                    o_cmd.upd_recv = 1'b1;
                    n_state        = S_MOD;
                end
            end
            S_CRED: begin
                if (!i_stat.div_busy) begin
                    if (i_stat.no_credit) begin
                        n_state = S_STAT;
                    end else begin
                        o_cmd.upd_sent = 1'b1;
                        n_state        = S_MOD;
                    end
                end
            end
            S_MOD: begin
                o_cmd.mod_rem = 1'b1;
                n_state       = i_stat.total_ge_block ? S_BLK : S_TAIL;
            end
            S_BLK: begin
                o_cmd.kind = EM_BLOCK;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.rem_zero ? S_IDLE : S_TAIL;
                end
            end
            S_TAIL: begin
                o_cmd.kind = EM_TAIL;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_STAT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/sdio_fifo_credit_transfer_planner_core.sv
// Top level of the SDIO FIFO credit and transfer planner.
// Depends on sfctp_pkg, sfctp_ifs, sfctp_ctrl, sfctp_dp and the macros header.
//
//   channel   dir   handshake       item
//   i_req     in    valid/ready     action, frame_length, token_word, length_word
//   o_res     out   valid/ready     one command or status descriptor, last on final
//   cfg       in    i_cfg_we        register index and 16-bit data, no wait
//
// One request at a time: a status-only request, a receive (with an optional byte-mode tail)
// or a send (likewise) is done before the next accept. A send waits on the one-bit-per-cycle
// credit divider; a send refused for credit ends in a status item.
// The block split is a reciprocal multiply and a remainder register.
// Synchronous active-low reset; no clearing pass. A stalled result sits in the output
// register and the next request is still taken; only the emitting state waits for it.
module sdio_fifo_credit_transfer_planner_core #(
    parameter int unsigned BLOCK_BYTES    = sfctp_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned RX_FRAME_LIMIT = sfctp_pkg::RX_FRAME_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sfctp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sfctp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    sfctp_req_if.sink                         i_req,
    sfctp_res_if.source                       o_res
);
    import sfctp_pkg::*;

    `include "sdio_fifo_credit_transfer_planner_core_macros.svh"

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    assign i_req.ready = w_in_ready;

    sfctp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sfctp_dp #(
        .BLOCK_BYTES    (BLOCK_BYTES),
        .RX_FRAME_LIMIT (RX_FRAME_LIMIT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_action       (i_req.action),
        .i_frame_length (i_req.frame_length),
        .i_token_word   (i_req.token_word),
        .i_length_word  (i_req.length_word),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_res          (o_res)
    );

    `SFCTP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready, "request taken while a request is in work")
    `SFCTP_ASSERT_IMPL(a_first_is_block, i_clk, i_rst_n, o_res.valid && !o_res.last, o_res.block_mode && o_res.status == ST_OK, "non-final item is not a block command")
    `SFCTP_ASSERT_IMPL(a_status_no_cmd, i_clk, i_rst_n, o_res.valid && o_res.status != ST_OK, o_res.chunk_bytes == '0 && o_res.command_address == '0, "status item carries a command")
    `SFCTP_ASSERT_IMPL(a_block_whole, i_clk, i_rst_n, o_res.valid && o_res.block_mode, o_res.payload_bytes == o_res.chunk_bytes && o_res.chunk_bytes != '0, "block command payload differs from chunk")

endmodule
